[src/pcc_pkg.sv]
// Package for the streaming Pearson correlation block: shared types, widths,
// status codes and the finisher state encoding. No dependencies.
package pcc_pkg;

    localparam int SampleW = 24;    // widest sample field
    localparam int CountW  = 17;    // pair count, wide enough to hold the limit
    localparam int SumW    = 40;    // sums of x and y
    localparam int SqW     = 64;    // sums of products
    localparam int MulW    = 82;    // signed operand width of the shared multiplier
    localparam int ProdW   = 2 * MulW;
    localparam int RootW   = 224;   // root search words, scaled by 2^60
    localparam int QW      = 31;    // magnitude of r in Q1.30

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_VX_ZERO  = 2'd1;
    localparam logic [1:0] STAT_VY_ZERO  = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [CountW-1:0]        count;
        logic signed [SumW-1:0]   sx;
        logic signed [SumW-1:0]   sy;
        logic signed [SqW-1:0]    sxy;
        logic signed [SqW-1:0]    sxx;
        logic signed [SqW-1:0]    syy;
        logic                     ovf;
    } pcc_sums_t;

    typedef enum logic [2:0] {
        FIN_IDLE,
        FIN_MSTART,
        FIN_MWAIT,
        FIN_RSUM,
        FIN_RCMP,
        FIN_OUT
    } pcc_fin_state_t;

endpackage

[src/pcc_front.sv]
// Front part: takes sample pairs, forms products and keeps the running sums.
// Pushes one snapshot of the sums per set into the queue. Depends on pcc_pkg.
module pcc_front import pcc_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SampleW-1:0]  x_in,
    input  logic [SampleW-1:0]  y_in,
    input  logic                last_in,
    output logic                push,
    input  logic                full,
    output pcc_sums_t           push_data
);

    localparam logic [CountW-1:0] CountLimit = CountW'((1 << COUNT_BITS) - 1);

    logic                         en;
    logic                         s1_valid_reg, s1_last_reg;
    logic signed [SampleW-1:0]    s1_x_reg, s1_y_reg;
    logic                         s2_valid_reg, s2_last_reg;
    logic signed [2*SampleW-1:0]  s2_xy_reg, s2_xx_reg, s2_yy_reg;
    logic signed [SampleW-1:0]    s2_x_reg, s2_y_reg;
    pcc_sums_t                    sums_reg, sums_next;
    logic                         keep;

    // Stall the whole pipe only when a set end meets a full queue.
    assign en       = !(s2_valid_reg && s2_last_reg && full);
    assign in_ready = en;
    assign push     = en && s2_valid_reg && s2_last_reg;
    assign keep     = sums_reg.count < CountLimit;

    always_comb
    begin
        sums_next = sums_reg;
        if (keep)
        begin
            sums_next.count = sums_reg.count + CountW'(1);
            sums_next.sx    = sums_reg.sx  + SumW'(s2_x_reg);
            sums_next.sy    = sums_reg.sy  + SumW'(s2_y_reg);
            sums_next.sxy   = sums_reg.sxy + SqW'(s2_xy_reg);
            sums_next.sxx   = sums_reg.sxx + SqW'(s2_xx_reg);
            sums_next.syy   = sums_reg.syy + SqW'(s2_yy_reg);
        end
        else
        begin
            sums_next.ovf = 1'b1;
        end
    end

    assign push_data = sums_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sums_reg     <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                // Clear the sums once the set is handed over.
                sums_reg <= s2_last_reg ? '0 : sums_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= SampleW'(signed'(x_in[SAMPLE_BITS-1:0]));
            s1_y_reg    <= SampleW'(signed'(y_in[SAMPLE_BITS-1:0]));
            s1_last_reg <= last_in;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_xy_reg   <= s1_x_reg * s1_y_reg;
            s2_xx_reg   <= s1_x_reg * s1_x_reg;
            s2_yy_reg   <= s1_y_reg * s1_y_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

[src/pcc_queue.sv]
// Two-entry queue of sum snapshots between the front and the finisher.
// Depends on pcc_pkg.
module pcc_queue import pcc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pcc_sums_t  push_data,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output pcc_sums_t  head
);

    pcc_sums_t  mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = fill_reg == 2'd2;
    assign empty = fill_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/pcc_mul.sv]
// Shared shift-and-add signed multiplier, one operand bit per cycle.
// Depends on pcc_pkg.
module pcc_mul import pcc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MulW-1:0]   a,
    input  logic signed [MulW-1:0]   b,
    output logic                     done,
    output logic signed [ProdW-1:0]  prod
);

    localparam int CntW = $clog2(MulW);

    logic              busy_reg, fin_reg, done_reg, neg_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [ProdW-1:0]  acc_reg, mc_reg;
    logic [MulW-1:0]   mp_reg;
    logic [MulW-1:0]   abs_a, abs_b;

    assign abs_a = a[MulW-1] ? MulW'(-a) : MulW'(a);
    assign abs_b = b[MulW-1] ? MulW'(-b) : MulW'(b);
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == CntW'(MulW - 1))
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= ProdW'(abs_a);
            mp_reg  <= abs_b;
            neg_reg <= a[MulW-1] ^ b[MulW-1];
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg  <= mc_reg << 1;
            mp_reg  <= mp_reg >> 1;
            cnt_reg <= cnt_reg + CntW'(1);
        end
        if (fin_reg)
        begin
            prod <= neg_reg ? signed'(-acc_reg) : signed'(acc_reg);
        end
    end

endmodule

[src/pcc_finish.sv]
// Back part: turns one snapshot of sums into r, status and count. Runs up to eight
// products on pcc_mul, then a bit-by-bit root search. Depends on pcc_pkg.
module pcc_finish import pcc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  pcc_sums_t   head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] correlation,
    output logic [1:0]  status,
    output logic [15:0] pair_count
);

    pcc_fin_state_t             state_reg, state_next;
    pcc_sums_t                  snap_reg;
    logic [2:0]                 k_reg;
    logic signed [ProdW-1:0]    t_reg;
    logic signed [MulW-1:0]     num_reg, vx_reg, vy_reg;
    logic [RootW-1:0]           rhs_reg, q2p_reg, u_reg, tt_reg, cand_reg;
    logic [QW-1:0]              q_reg, q_fin;
    logic [4:0]                 bit_reg;
    logic                       mul_start, mul_done;
    logic signed [MulW-1:0]     op_a, op_b, abs_num;
    logic signed [ProdW-1:0]    mul_prod, diff_full;
    logic signed [MulW-1:0]     diff;
    logic                       take;

    pcc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign abs_num   = num_reg[MulW-1] ? -num_reg : num_reg;
    assign diff_full = t_reg - mul_prod;
    assign diff      = diff_full[MulW-1:0];
    assign take      = !q_reg[QW-1] && (cand_reg <= rhs_reg);
    assign q_fin     = take ? (q_reg | (QW'(1) << bit_reg)) : q_reg;

    always_comb
    begin
        unique case (k_reg)
            3'd0:    begin op_a = MulW'(signed'({1'b0, snap_reg.count})); op_b = MulW'(snap_reg.sxy); end
            3'd1:    begin op_a = MulW'(snap_reg.sx); op_b = MulW'(snap_reg.sy); end
            3'd2:    begin op_a = MulW'(signed'({1'b0, snap_reg.count})); op_b = MulW'(snap_reg.sxx); end
            3'd3:    begin op_a = MulW'(snap_reg.sx); op_b = MulW'(snap_reg.sx); end
            3'd4:    begin op_a = MulW'(signed'({1'b0, snap_reg.count})); op_b = MulW'(snap_reg.syy); end
            3'd5:    begin op_a = MulW'(snap_reg.sy); op_b = MulW'(snap_reg.sy); end
            3'd6:    begin op_a = vx_reg; op_b = vy_reg; end
            default: begin op_a = abs_num; op_b = abs_num; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FIN_IDLE:
                if (!empty)
                begin
                    state_next = head.ovf ? FIN_OUT : FIN_MSTART;
                end
            FIN_MSTART:
                state_next = FIN_MWAIT;
            FIN_MWAIT:
                if (mul_done)
                begin
                    if ((k_reg == 3'd3 || k_reg == 3'd5) && diff == '0)
                    begin
                        state_next = FIN_OUT;
                    end
                    else if (k_reg == 3'd7)
                    begin
                        state_next = FIN_RSUM;
                    end
                    else
                    begin
                        state_next = FIN_MSTART;
                    end
                end
            FIN_RSUM:
                state_next = FIN_RCMP;
            FIN_RCMP:
                state_next = (bit_reg == 5'd0) ? FIN_OUT : FIN_RSUM;
            FIN_OUT:
                if (out_ready)
                begin
                    state_next = FIN_IDLE;
                end
            default:
                state_next = FIN_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == FIN_IDLE) && !empty;
        mul_start = state_reg == FIN_MSTART;
        out_valid = state_reg == FIN_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FIN_IDLE:
                if (!empty)
                begin
                    snap_reg    <= head;
                    k_reg       <= 3'd0;
                    correlation <= '0;
                    status      <= head.ovf ? STAT_OVERFLOW : STAT_OK;
                    pair_count  <= head.count[15:0];
                end
            FIN_MWAIT:
                if (mul_done)
                begin
                    k_reg <= k_reg + 3'd1;
                    case (k_reg)
                        3'd1: num_reg <= diff;
                        3'd3:
                        begin
                            vx_reg <= diff;
                            if (diff == '0)
                            begin
                                status <= STAT_VX_ZERO;
                            end
                        end
                        3'd5:
                        begin
                            vy_reg <= diff;
                            if (diff == '0)
                            begin
                                status <= STAT_VY_ZERO;
                            end
                        end
                        3'd6:
                        begin
                            tt_reg <= RootW'(unsigned'(mul_prod)) << 60;
                        end
                        3'd7:
                        begin
                            rhs_reg <= RootW'(unsigned'(mul_prod)) << 60;
                            q2p_reg <= '0;
                            u_reg   <= '0;
                            q_reg   <= '0;
                            bit_reg <= 5'd30;
                        end
                        default: t_reg <= mul_prod;
                    endcase
                end
            FIN_RSUM:
                cand_reg <= q2p_reg + u_reg + tt_reg;
            FIN_RCMP:
            begin
                // Keep q^2*P, 2^(b+1)*q*P and 2^(2b)*P in step with the bit.
                if (take)
                begin
                    q2p_reg <= cand_reg;
                    u_reg   <= (u_reg >> 1) + tt_reg;
                end
                else
                begin
                    u_reg <= u_reg >> 1;
                end
                tt_reg  <= tt_reg >> 2;
                q_reg   <= q_fin;
                bit_reg <= bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    correlation <= num_reg[MulW-1] ? -(32'(q_fin)) : 32'(q_fin);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[src/pearson_correlation_stream_top.sv]
// Streaming Pearson correlation coefficient, top level.
// Input slave stream: one (x, y) pair per transfer, tlast marks the set end.
// Output master stream: one transfer per set with r in Q1.30, status, count.
// Accumulation runs at one pair per cycle unless a set end meets a full queue;
// a set's sums are pushed from s2 and the finisher pops them when idle.
// The finisher runs eight products, one after another, on a single
// bit-serial 82x82 multiplier, then a 31-bit root search over 224-bit words
// with an RSUM and an RCMP state per bit. Flat or overflowed sets end early.
// A two-set queue lets the input keep streaming while a set is finished; the
// input stalls only when a set end arrives with both queue entries taken.
// When the receiver stalls, the result is held in its output register and
// the finisher waits; queued sets stay put.
// Reset clears the sums, count, overflow flag, queue and finisher state.
// Status: 0 ok, 1 x variance zero, 2 y variance zero, 3 more than
// 2^COUNT_BITS-1 pairs (extra pairs are dropped). r is zero unless status is 0.
// Depends on pcc_pkg, pcc_front, pcc_queue, pcc_mul, pcc_finish.
module pearson_correlation_stream_top import pcc_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_sample [23:0], y_sample [47:24]
    input  logic        s_tlast,   // last_pair
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // correlation [31:0], pair_count [47:32]
    output logic [1:0]  m_tuser    // status [1:0]
);

    logic       push, full, pop, empty;
    pcc_sums_t  push_data, head;
    logic [31:0] correlation;
    logic [15:0] pair_count;

    // Front: products and running sums, one pair per cycle unless stalled.
    pcc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_in      (s_tdata[23:0]),
        .y_in      (s_tdata[47:24]),
        .last_in   (s_tlast),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    // Hold finished sets until the finisher is free.
    pcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    // Back: exact numerator, variances and root search.
    pcc_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .correlation (correlation),
        .status      (m_tuser),
        .pair_count  (pair_count)
    );

    assign m_tdata = {pair_count, correlation};

endmodule
